// File: rtl/core/bilinear_rgba_sampler_core_macros.svh
// assertion macros for the bilinear rgba sampler core
// used by files that check their own logic; needs i_clk and i_rst_n in scope
`ifndef BILINEAR_RGBA_SAMPLER_CORE_MACROS_SVH
`define BILINEAR_RGBA_SAMPLER_CORE_MACROS_SVH
`ifndef SYNTH
// checked while out of reset
`define RBS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("rbs check failed");
// checked on every edge, reset included
`define RBS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) else $error("rbs check failed");
`else
`define RBS_ASSERT(lbl, prop)
`define RBS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: rtl/core/rbs_pkg.sv
// shared types, constants and helpers of the bilinear rgba sampler
// no dependencies
package rbs_pkg;
    localparam int FRAC_BITS    = 8;
    localparam int CHANNEL_BITS = 16;
    localparam int COORD_BITS   = 18;
    localparam int INT_BITS     = COORD_BITS - FRAC_BITS;
    localparam int SIZE_BITS    = 9;
    localparam int POS_BITS     = 8;
    localparam int LIM_BITS     = 13;
    localparam int NUM_CH       = 4;
    localparam int NUM_BANKS    = 4;
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(256);

    typedef enum logic [0:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic [0:0] {
        MODE_WRITE  = 1'b0,
        MODE_SAMPLE = 1'b1
    } t_mode;

    // channel 0 red, 1 green, 2 blue, 3 alpha
    typedef logic [NUM_CH-1:0][CHANNEL_BITS-1:0] t_pix;

    typedef struct packed {
        logic                           mode;
        logic [POS_BITS-1:0]            write_col;
        logic [POS_BITS-1:0]            write_row;
        t_pix                           pix;
        logic signed [COORD_BITS-1:0]   sample_x;
        logic signed [COORD_BITS-1:0]   sample_y;
    } t_in_item;

    // neighbor parities pick the bank of each corner
    typedef struct packed {
        logic                   valid;
        logic                   x0p;
        logic                   x1p;
        logic                   y0p;
        logic                   y1p;
        logic [FRAC_BITS-1:0]   fx;
        logic [FRAC_BITS-1:0]   fy;
    } t_sel;

    // size register to usable limit: zero means one, saturate at max
    function automatic logic [LIM_BITS-1:0] lim_of(input logic [SIZE_BITS-1:0] v,
                                                  input logic [LIM_BITS-1:0] mx);
        logic [LIM_BITS-1:0] ve;
        ve = LIM_BITS'(v);
        if (v == '0) return LIM_BITS'(1);
        else if (ve > mx) return mx;
        else return ve;
    endfunction

    // clamp a signed neighbor index to [0, lim-1]
    function automatic logic [LIM_BITS-1:0] clamp_idx(input logic signed [INT_BITS+1:0] v,
                                                     input logic [LIM_BITS-1:0] lim);
        logic [LIM_BITS-1:0] ve;
        ve = LIM_BITS'($unsigned(v));
        if (v < 0) return '0;
        else if (ve >= lim) return lim - LIM_BITS'(1);
        else return ve;
    endfunction
endpackage

// File: rtl/core/rbs_in_if.sv
// input channel of the sampler: valid, ready and one write or sample item
// depends on rbs_pkg
interface rbs_in_if import rbs_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic                           mode;
    logic [POS_BITS-1:0]            write_col;
    logic [POS_BITS-1:0]            write_row;
    logic [CHANNEL_BITS-1:0]        red_in;
    logic [CHANNEL_BITS-1:0]        green_in;
    logic [CHANNEL_BITS-1:0]        blue_in;
    logic [CHANNEL_BITS-1:0]        alpha_in;
    logic signed [COORD_BITS-1:0]   sample_x;
    logic signed [COORD_BITS-1:0]   sample_y;

    modport source (output valid, mode, write_col, write_row, red_in, green_in,
                    blue_in, alpha_in, sample_x, sample_y, input ready);
    modport sink (input valid, mode, write_col, write_row, red_in, green_in,
                  blue_in, alpha_in, sample_x, sample_y, output ready);
endinterface

// File: rtl/core/rbs_out_if.sv
// result channel of the sampler: valid, ready and four blended channels
// depends on rbs_pkg
interface rbs_out_if import rbs_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [CHANNEL_BITS-1:0]    red_out;
    logic [CHANNEL_BITS-1:0]    green_out;
    logic [CHANNEL_BITS-1:0]    blue_out;
    logic [CHANNEL_BITS-1:0]    alpha_out;

    modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
    modport sink (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

// File: rtl/core/rbs_addr.sv
// address stage: size registers, floor and clamp of neighbors, bank addresses
// depends on rbs_pkg
module rbs_addr import rbs_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int HXW = 1,
    parameter int HYW = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic                        i_valid,
    input  t_in_item                    i_item,
    input  logic                        i_cfg_we,
    input  logic [0:0]                  i_cfg_idx,
    input  logic [SIZE_BITS-1:0]        i_cfg_wdata,
    output t_sel                        o_sel,
    output logic [NUM_BANKS-1:0]        o_we,
    output t_pix                        o_wpix,
    output logic [NUM_BANKS-1:0][HYW+HXW-1:0] o_addr
);
    localparam logic [LIM_BITS-1:0] MAXW = LIM_BITS'(MAX_WIDTH);
    localparam logic [LIM_BITS-1:0] MAXH = LIM_BITS'(MAX_HEIGHT);

    logic [LIM_BITS-1:0] r_w_lim, r_h_lim;
    t_sel r_sel;
    logic [NUM_BANKS-1:0] r_we, n_we;
    t_pix r_wpix;
    logic [NUM_BANKS-1:0][HYW+HXW-1:0] r_addr, n_addr;

    logic signed [INT_BITS+1:0] ix0, ix1, iy0, iy1;
    logic [FRAC_BITS-1:0] fx, fy;
    logic [LIM_BITS-1:0] x0, x1, y0, y1, xe, xo, ye, yo;
    logic [LIM_BITS-1:0] wc, wr;
    logic [HXW-1:0] ce, co, wch;
    logic [HYW-1:0] re, ro, wrh;
    logic w_ok;
    t_sel n_sel;

    // size limits, resolved once at write time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_lim <= lim_of(SIZE_RESET, MAXW);
            r_h_lim <= lim_of(SIZE_RESET, MAXH);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_WIDTH:  r_w_lim <= lim_of(i_cfg_wdata, MAXW);
                CFG_HEIGHT: r_h_lim <= lim_of(i_cfg_wdata, MAXH);
                default:    r_w_lim <= r_w_lim;
            endcase
        end
    end

    // floor, ceiling and clamp of both axes
    always_comb begin
        fx  = i_item.sample_x[FRAC_BITS-1:0];
        fy  = i_item.sample_y[FRAC_BITS-1:0];
        ix0 = {{2{i_item.sample_x[COORD_BITS-1]}}, i_item.sample_x[COORD_BITS-1:FRAC_BITS]};
        iy0 = {{2{i_item.sample_y[COORD_BITS-1]}}, i_item.sample_y[COORD_BITS-1:FRAC_BITS]};
        ix1 = ix0 + (INT_BITS+2)'(fx != '0);
        iy1 = iy0 + (INT_BITS+2)'(fy != '0);
        x0 = clamp_idx(ix0, r_w_lim);
        x1 = clamp_idx(ix1, r_w_lim);
        y0 = clamp_idx(iy0, r_h_lim);
        y1 = clamp_idx(iy1, r_h_lim);
        // even and odd neighbor of each axis
        xe = x0[0] ? x1 : x0;
        xo = x0[0] ? x0 : x1;
        ye = y0[0] ? y1 : y0;
        yo = y0[0] ? y0 : y1;
        ce = HXW'(xe >> 1);
        co = HXW'(xo >> 1);
        re = HYW'(ye >> 1);
        ro = HYW'(yo >> 1);
        wc = LIM_BITS'(i_item.write_col);
        wr = LIM_BITS'(i_item.write_row);
        wch = HXW'(wc >> 1);
        wrh = HYW'(wr >> 1);
        w_ok = (wc < MAXW) && (wr < MAXH);

        n_sel.valid = i_valid && (i_item.mode == MODE_SAMPLE);
        n_sel.x0p = x0[0];
        n_sel.x1p = x1[0];
        n_sel.y0p = y0[0];
        n_sel.y1p = y1[0];
        n_sel.fx  = fx;
        n_sel.fy  = fy;

        for (int b = 0; b < NUM_BANKS; b++) begin
            n_we[b] = i_valid && (i_item.mode == MODE_WRITE) && w_ok
                      && (2'(b) == {wr[0], wc[0]});
        end
        if (i_item.mode == MODE_WRITE) begin
            for (int b = 0; b < NUM_BANKS; b++) n_addr[b] = {wrh, wch};
        end else begin
            n_addr[0] = {re, ce};
            n_addr[1] = {re, co};
            n_addr[2] = {ro, ce};
            n_addr[3] = {ro, co};
        end
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel.valid <= 1'b0;
            r_we        <= '0;
        end else if (i_adv) begin
            r_sel <= n_sel;
            r_we  <= n_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_wpix    <= i_item.pix;
            r_addr    <= n_addr;
        end
    end

    assign o_sel  = r_sel;
    assign o_we   = r_we;
    assign o_wpix = r_wpix;
    assign o_addr = r_addr;
endmodule

// File: rtl/core/rbs_bank.sv
// one pixel bank: single access per cycle while enabled, write or registered read
// depends on rbs_pkg
module rbs_bank import rbs_pkg::*; #(
    parameter int AW = 14
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic            i_we,
    input  logic [AW-1:0]   i_addr,
    input  t_pix            i_wdata,
    output t_pix            o_rdata
);
    localparam int DEPTH = 1 << AW;

    t_pix r_mem [DEPTH];
    t_pix r_rdata;

    // write or read, held while the pipeline stalls
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) r_mem[i_addr] <= i_wdata;
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/core/rbs_blend.sv
// blend stages: corner select and x lerp, y lerp, round to nearest
// depends on rbs_pkg
module rbs_blend import rbs_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  t_sel                        i_sel,
    input  t_pix [NUM_BANKS-1:0]        i_bank,
    output logic                        o_valid,
    output t_pix                        o_pix
);
    localparam int HW  = CHANNEL_BITS + FRAC_BITS + 1;
    localparam int SW  = HW + FRAC_BITS + 1;
    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;
    localparam logic [SW-1:0] HALF = SW'(1) << (2 * FRAC_BITS - 1);

    t_pix pa, pb, pc, pd;
    logic [FRAC_BITS:0] wx0, wx1, wy0, wy1;
    logic [NUM_CH-1:0][HW-1:0] n_top, n_bot, r_top, r_bot;
    logic [NUM_CH-1:0][SW-1:0] n_sum, r_sum;
    logic [FRAC_BITS-1:0] r_fy;
    logic r_vc, r_vd, r_ve;
    t_pix r_out, n_out;

    // corners from bank by parity, then horizontal lerp
    always_comb begin
        pa = i_bank[{i_sel.y0p, i_sel.x0p}];
        pb = i_bank[{i_sel.y0p, i_sel.x1p}];
        pc = i_bank[{i_sel.y1p, i_sel.x0p}];
        pd = i_bank[{i_sel.y1p, i_sel.x1p}];
        wx1 = (FRAC_BITS+1)'(i_sel.fx);
        wx0 = ONE - wx1;
        for (int c = 0; c < NUM_CH; c++) begin
            n_top[c] = HW'(pa[c]) * HW'(wx0) + HW'(pb[c]) * HW'(wx1);
            n_bot[c] = HW'(pc[c]) * HW'(wx0) + HW'(pd[c]) * HW'(wx1);
        end
    end

    // vertical lerp
    always_comb begin
        wy1 = (FRAC_BITS+1)'(r_fy);
        wy0 = ONE - wy1;
        for (int c = 0; c < NUM_CH; c++) begin
            n_sum[c] = SW'(r_top[c]) * SW'(wy0) + SW'(r_bot[c]) * SW'(wy1);
        end
    end

    // round once, ties up
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            n_out[c] = CHANNEL_BITS'((r_sum[c] + HALF) >> (2 * FRAC_BITS));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
        end else if (i_adv) begin
            r_vc <= i_sel.valid;
            r_vd <= r_vc;
            r_ve <= r_vd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_top <= n_top;
            r_bot <= n_bot;
            r_fy  <= i_sel.fy;
            r_sum <= n_sum;
            r_out <= n_out;
        end
    end

    assign o_valid = r_ve;
    assign o_pix   = r_out;
endmodule

// File: rtl/core/bilinear_rgba_sampler_core.sv
// Bilinear RGBA sampler with clamp-to-edge addressing. Takes one item per clock
// while no held result stalls the pipeline: a pixel write or a sample. The image
// sits in four banks split by column and row parity, so the four neighbors of a
// sample are read from four different banks at once. Stages: address and clamp,
// bank read, x lerp, y lerp, rounding into the output register. The store is not
// cleared; sample only pixels that were written. The user must write the size
// registers only while idle; the block itself does not enforce this.
// depends on rbs_pkg, rbs_in_if, rbs_out_if, rbs_addr, rbs_bank, rbs_blend
`include "bilinear_rgba_sampler_core_macros.svh"
module bilinear_rgba_sampler_core import rbs_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    rbs_in_if.sink                  i_in,
    rbs_out_if.source               o_out,
    input  logic                    i_cfg_we,
    input  logic [0:0]              i_cfg_idx,
    input  logic [SIZE_BITS-1:0]    i_cfg_wdata
);
    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int HXW = (XW > 1) ? XW - 1 : 1;
    localparam int HYW = (YW > 1) ? YW - 1 : 1;
    localparam int AW  = HXW + HYW;

    logic adv;
    t_in_item item;
    t_sel w_sel, r_selb;
    logic [NUM_BANKS-1:0] w_we;
    t_pix w_wpix, b_pix;
    logic [NUM_BANKS-1:0][AW-1:0] w_addr;
    t_pix [NUM_BANKS-1:0] w_bank;
    logic b_valid;

    // whole pipeline moves unless a held result blocks it
    assign adv        = !o_out.valid || o_out.ready;
    assign i_in.ready = adv;

    assign item.mode      = i_in.mode;
    assign item.write_col = i_in.write_col;
    assign item.write_row = i_in.write_row;
    assign item.pix       = {i_in.alpha_in, i_in.blue_in, i_in.green_in, i_in.red_in};
    assign item.sample_x  = i_in.sample_x;
    assign item.sample_y  = i_in.sample_y;

    rbs_addr #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .HXW       (HXW),
        .HYW       (HYW)
    ) u_addr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_valid    (i_in.valid),
        .i_item     (item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .o_sel      (w_sel),
        .o_we       (w_we),
        .o_wpix     (w_wpix),
        .o_addr     (w_addr)
    );

    // pixel banks by parity
    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        rbs_bank #(.AW(AW)) u_bank (
            .i_clk  (i_clk),
            .i_en   (adv),
            .i_we   (w_we[b]),
            .i_addr (w_addr[b]),
            .i_wdata(w_wpix),
            .o_rdata(w_bank[b])
        );
    end

    // select info travels alongside the bank read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_selb.valid <= 1'b0;
        end else if (adv) begin
            r_selb <= w_sel;
        end
    end

    rbs_blend u_blend (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_adv  (adv),
        .i_sel  (r_selb),
        .i_bank (w_bank),
        .o_valid(b_valid),
        .o_pix  (b_pix)
    );

    assign o_out.valid     = b_valid;
    assign o_out.red_out   = b_pix[0];
    assign o_out.green_out = b_pix[1];
    assign o_out.blue_out  = b_pix[2];
    assign o_out.alpha_out = b_pix[3];

    // checks
    `RBS_ASSERT(a_one_bank_write, $onehot0(w_we))
    `RBS_ASSERT(a_write_no_sample, (w_we != '0) |-> !w_sel.valid)
    `RBS_ASSERT(a_stall_holds_addr, !adv |=> $stable(w_sel) && $stable(w_we))
    `RBS_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !o_out.valid)
endmodule

// File: test/tb_bilinear_rgba_sampler_core.sv
// testbench for the bilinear rgba sampler core: pixel writes, clamped bilinear samples
// depends on rbs_pkg, rbs_in_if, rbs_out_if and bilinear_rgba_sampler_core
`timescale 1ns / 1ps

// expected blends kept in order of sample transfer, checked against each result
class rgba_scoreboard;
    rbs_pkg::t_pix image_copy [65536];
    bit [8:0]      width_reg;
    bit [8:0]      height_reg;
    rbs_pkg::t_pix blend_queue [$];
    int            mismatches;

    function new();
        width_reg  = 9'd256;
        height_reg = 9'd256;
        mismatches = 0;
    endfunction

    function int usable_size(bit [8:0] v);
        if (v == 0) return 1;
        if (v > 256) return 256;
        return v;
    endfunction

    function int edge_clamp(int v, int lim);
        if (v < 0) return 0;
        if (v >= lim) return lim - 1;
        return v;
    endfunction

    // write updates the image copy, sample predicts one blended pixel
    function void note_input(rbs_pkg::t_in_item it);
        int w, h, ix, iy, fx, fy, x0, x1, y0, y1;
        longint top, bot, sum;
        rbs_pkg::t_pix a, b, c, d, res;
        if (it.mode == rbs_pkg::MODE_WRITE) begin
            image_copy[{it.write_row, it.write_col}] = it.pix;
            return;
        end
        w  = usable_size(width_reg);
        h  = usable_size(height_reg);
        ix = int'(it.sample_x >>> 8);
        iy = int'(it.sample_y >>> 8);
        fx = it.sample_x[7:0];
        fy = it.sample_y[7:0];
        x0 = edge_clamp(ix, w);
        x1 = edge_clamp(ix + (fx != 0), w);
        y0 = edge_clamp(iy, h);
        y1 = edge_clamp(iy + (fy != 0), h);
        a = image_copy[y0 * 256 + x0];
        b = image_copy[y0 * 256 + x1];
        c = image_copy[y1 * 256 + x0];
        d = image_copy[y1 * 256 + x1];
        for (int ch = 0; ch < 4; ch++) begin
            top = longint'(a[ch]) * (256 - fx) + longint'(b[ch]) * fx;
            bot = longint'(c[ch]) * (256 - fx) + longint'(d[ch]) * fx;
            sum = top * (256 - fy) + bot * fy;
            res[ch] = 16'((sum + 32768) >> 16);
        end
        blend_queue.push_back(res);
    endfunction

    function void report_mismatch(string what, rbs_pkg::t_pix exp_pix, rbs_pkg::t_pix got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected r=%h g=%h b=%h a=%h got r=%h g=%h b=%h a=%h",
                     what, exp_pix[0], exp_pix[1], exp_pix[2], exp_pix[3],
                     got[0], got[1], got[2], got[3]);
    endfunction

    function void check_result(rbs_pkg::t_pix got);
        rbs_pkg::t_pix exp_pix;
        if (blend_queue.size() == 0) begin
            report_mismatch("unexpected result", '0, got);
            return;
        end
        exp_pix = blend_queue.pop_front();
        if (got[0] !== exp_pix[0]) report_mismatch("red", exp_pix, got);
        if (got[1] !== exp_pix[1]) report_mismatch("green", exp_pix, got);
        if (got[2] !== exp_pix[2]) report_mismatch("blue", exp_pix, got);
        if (got[3] !== exp_pix[3]) report_mismatch("alpha", exp_pix, got);
    endfunction
endclass

module tb_bilinear_rgba_sampler_core;
    import rbs_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 12;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [0:0]           i_cfg_idx;
    logic [SIZE_BITS-1:0] i_cfg_wdata;

    rbs_in_if  in_if();
    rbs_out_if out_if();

    bilinear_rgba_sampler_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    rgba_scoreboard sb;
    bit             written [65536];
    bit             no_gaps;
    bit             hold_req;
    int             region_w;
    int             region_h;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_WIDTH;
        i_cfg_wdata     = '0;
        in_if.valid     = 1'b0;
        in_if.mode      = MODE_WRITE;
        in_if.write_col = '0;
        in_if.write_row = '0;
        in_if.red_in    = '0;
        in_if.green_in  = '0;
        in_if.blue_in   = '0;
        in_if.alpha_in  = '0;
        in_if.sample_x  = '0;
        in_if.sample_y  = '0;
        out_if.ready    = 1'b0;
    end

    // monitor of both channels feeds the scoreboard
    always @(posedge i_clk) begin
        t_in_item it;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            it.mode      = in_if.mode;
            it.write_col = in_if.write_col;
            it.write_row = in_if.write_row;
            it.pix       = {in_if.alpha_in, in_if.blue_in, in_if.green_in, in_if.red_in};
            it.sample_x  = in_if.sample_x;
            it.sample_y  = in_if.sample_y;
            sb.note_input(it);
        end
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_result({out_if.alpha_out, out_if.blue_out, out_if.green_out,
                             out_if.red_out});
    end

    // watchdog on cycles without any transfer
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
            else quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // result side: random hold-offs, one long hold on request
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_if.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_req = 1'b0;
            end
            gap = no_gaps ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                out_if.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_if.ready = 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
        end
    end

    task automatic send_item(t_in_item it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid     = 1'b1;
        in_if.mode      = it.mode;
        in_if.write_col = it.write_col;
        in_if.write_row = it.write_row;
        in_if.red_in    = it.pix[0];
        in_if.green_in  = it.pix[1];
        in_if.blue_in   = it.pix[2];
        in_if.alpha_in  = it.pix[3];
        in_if.sample_x  = it.sample_x;
        in_if.sample_y  = it.sample_y;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic write_pixel(int col, int row, t_pix pix);
        t_in_item it;
        it           = '0;
        it.mode      = MODE_WRITE;
        it.write_col = col[7:0];
        it.write_row = row[7:0];
        it.pix       = pix;
        it.sample_x  = 18'($urandom);
        it.sample_y  = 18'($urandom);
        written[row * 256 + col] = 1'b1;
        send_item(it);
    endtask

    task automatic sample_at(logic signed [17:0] x, logic signed [17:0] y);
        t_in_item it;
        it.mode      = MODE_SAMPLE;
        it.write_col = 8'($urandom);
        it.write_row = 8'($urandom);
        it.pix       = {$urandom, $urandom};
        it.sample_x  = x;
        it.sample_y  = y;
        send_item(it);
    endtask

    // idle the input, wait out every result and the pipeline, then reprogram
    task automatic set_size(bit [8:0] w, bit [8:0] h);
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (sb.blend_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = CFG_WIDTH;
        i_cfg_wdata = w;
        @(negedge i_clk);
        i_cfg_idx   = CFG_HEIGHT;
        i_cfg_wdata = h;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        sb.width_reg  = w;
        sb.height_reg = h;
        region_w = sb.usable_size(w);
        region_h = sb.usable_size(h);
    endtask

    // every pixel a sample can reach must hold a written value
    task automatic fill_region(bit extremes);
        t_pix pix;
        for (int r = 0; r < region_h; r++)
            for (int c = 0; c < region_w; c++)
                if (!written[r * 256 + c]) begin
                    if (extremes) pix = ((r + c) % 2) ? '1 : '0;
                    else pix = {$urandom, $urandom};
                    write_pixel(c, r, pix);
                end
    endtask

    function automatic logic signed [17:0] pick_coord(int lim);
        int pos;
        if ($urandom_range(0, 9) == 0) return 18'($urandom);
        pos = $urandom_range(0, lim + 3) - 2;
        case ($urandom_range(0, 3))
            0: return 18'(pos * 256);
            1: return 18'(pos * 256 + 128);
            default: return 18'(pos * 256 + $urandom_range(0, 255));
        endcase
    endfunction

    task automatic random_items(int count);
        for (int n = 0; n < count; n++) begin
            if (n % 60 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 35)
                write_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                            {$urandom, $urandom});
            else
                sample_at(pick_coord(region_w), pick_coord(region_h));
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        bit [8:0] widths  [7];
        bit [8:0] heights [7];
        sb       = new();
        no_gaps  = 1'b0;
        hold_req = 1'b0;
        region_w = 256;
        region_h = 256;
        widths  = '{9'd4, 9'd511, 9'd0, 9'd9, 9'd2, 9'd16, 9'd1};
        heights = '{9'd4, 9'd0, 9'd511, 9'd7, 9'd2, 9'd16, 9'd256};
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int p = 0; p < 7; p++) begin
            set_size(widths[p], heights[p]);
            fill_region(p == 0);
            if (p == 0) begin
                // directed: corners, far and negative coordinates, pure fractions
                write_pixel(255, 255, '1);
                write_pixel(200, 17, '0);
                sample_at(18'sd0, 18'sd0);
                sample_at(18'sd131071, 18'sd131071);
                sample_at(-18'sd131072, -18'sd131072);
                sample_at(18'sd131071, -18'sd131072);
                sample_at(-18'sd1, -18'sd1);
                sample_at(18'sd128, 18'sd128);
                sample_at(18'sd255, 18'sd1);
                sample_at(18'sd640, 18'sd896);
                sample_at(18'sd768, 18'sd768);
                sample_at(18'sd832, 18'sd100);
                sample_at(18'sd256, 18'sd512);
                sample_at(-18'sd300, 18'sd400);
                sample_at(18'sd1023, 18'sd1023);
            end
            if (p == 3) begin
                random_items(55);
                hold_req = 1'b1;
                random_items(80);
            end else begin
                random_items(135);
            end
        end

        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (sb.blend_queue.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.blend_queue.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// File: bilinear_rgba_sampler_core.f
+incdir+rtl/core
rtl/core/rbs_pkg.sv
rtl/core/rbs_in_if.sv
rtl/core/rbs_out_if.sv
rtl/core/rbs_addr.sv
rtl/core/rbs_bank.sv
rtl/core/rbs_blend.sv
rtl/core/bilinear_rgba_sampler_core.sv
test/tb_bilinear_rgba_sampler_core.sv
